// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef logic [0:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_INSERT = 1'b0;
  localparam opcode_t OP_DELETE = 1'b1;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  // command from the controller to the datapath
  typedef struct packed {
    logic    exec;
    opcode_t op;
  } spq_cmd_t;

endpackage

// ===== sv/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// valid/ready channels of the sorted priority queue
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  opcode_t                      opcode;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FILL_W     = 5
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_out;
  status_t                      status;
  logic [FILL_W-1:0]            fill;

  modport source (output valid, output value_out, output status, output fill, input ready);
  modport sink   (input valid, input value_out, input status, input fill, output ready);
endinterface

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: tracks whether a result beat is held
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  opcode_t  in_opcode,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == S_HOLD);
  assign cmd.exec  = accept;
  assign cmd.op    = in_opcode;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept)         state_nxt = S_HOLD;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== sv/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// row of sorted cells, entry count and result register
// ----------------------------------------------------------------------------
module spq_dp
  import spq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int FILL_W     = 5
)(
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_cmd_t                     cmd,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output status_t                      out_status,
  output logic [FILL_W-1:0]            out_fill
);

  localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(DEPTH);

  logic signed [DATA_WIDTH-1:0] ent_r   [DEPTH];
  logic signed [DATA_WIDTH-1:0] ent_nxt [DEPTH];
  logic [DEPTH-1:0]             gt;
  logic [FILL_W-1:0]            cnt_r;
  logic [FILL_W-1:0]            cnt_nxt;
  logic                         is_full;
  logic                         is_empty;
  logic                         wr_en;
  status_t                      status_nxt;
  logic signed [DATA_WIDTH-1:0] value_nxt;

  assign is_full  = (cnt_r == DEPTH_C);
  assign is_empty = (cnt_r == '0);

  // per-cell compare and shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [FILL_W-1:0] IDX = FILL_W'(i);

    assign gt[i] = (IDX < cnt_r) && (ent_r[i] > in_value);

    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (cmd.op == OP_INSERT) begin
        // greater cells and the first free cell take the left neighbor or the new value
        if (gt[i] || (IDX == cnt_r)) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) ent_nxt[i] = ent_r[(i > 0) ? i - 1 : 0];
          else                                 ent_nxt[i] = in_value;
        end
      end else begin
        if (i < DEPTH - 1) ent_nxt[i] = ent_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en) ent_r[i] <= ent_nxt[i];
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = STATUS_OK;
    value_nxt  = '0;
    wr_en      = 1'b0;
    if (cmd.op == OP_INSERT) begin
      if (is_full) begin
        status_nxt = STATUS_FULL;
      end else begin
        wr_en   = cmd.exec;
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_nxt = STATUS_EMPTY;
      end else begin
        wr_en     = cmd.exec;
        cnt_nxt   = cnt_r - 1'b1;
        value_nxt = ent_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        cnt_r <= '0;
    else if (cmd.exec) cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_value  <= value_nxt;
      out_status <= status_nxt;
      out_fill   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// min-priority queue kept as an ascending sorted row of registers
// ----------------------------------------------------------------------------
// Each input beat is either an insert (opcode 0) or a delete-min (opcode 1),
// and each gives exactly one result beat carrying value_out, status and fill.
// An insert lands behind every held entry that is not greater, so equal
// values leave in arrival order; an insert into a full queue is refused with
// status full, and a delete-min on an empty queue returns status empty with
// value zero. Every cell compares its entry with the incoming value at once
// and shifts locally, so an operation completes in the cycle it is accepted
// and its result sits in the output register the next cycle. One beat is
// taken per cycle as long as the result side keeps draining; the single
// output register is what sets that figure, since a new beat is accepted
// whenever the held result is empty or taken in the same cycle. No clearing
// pass is needed after reset: only the entry count and the handshake state
// are cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int FILL_W     = $clog2(DEPTH + 1)
)(
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  // command from controller to datapath
  spq_cmd_t cmd;

  // handshake and sequencing
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // sorted cells, count and result register
  spq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .FILL_W     (FILL_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_ch.value),
    .out_value  (out_ch.value_out),
    .out_status (out_ch.status),
    .out_fill   (out_ch.fill)
  );

endmodule
